[rtl/pva_pkg.sv]
// Shared types and constants for the polyphonic voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

  // Default voice count
  localparam int VOICES_DEF = 8;

  // Depth of the command queue between front and back end
  localparam int CMD_DEPTH = 2;

  // MIDI message kinds
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_CTRL     = 2'd2;

  // Sustain pedal controller and its switch threshold
  localparam logic [6:0] SUSTAIN_CC     = 7'd64;
  localparam logic [6:0] SUSTAIN_THRESH = 7'd63;

  // Age stamp counter value after reset
  localparam logic [31:0] AGE_RESET = 32'd1;

  // Commands handed from front end to back end
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_NOTE_ON  = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_SUS_ON   = 3'd3,
    OP_SUS_OFF  = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] note;
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

endpackage

[rtl/pva_front.sv]
// Front end: channel filter, message classification and channel register.
`timescale 1ns / 1ps

module pva_front
  import pva_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  input  logic       msg_valid,
  output logic       msg_ready,
  input  logic [1:0] kind,
  input  logic [3:0] channel,
  input  logic [6:0] data_first,
  input  logic [6:0] data_second,
  input  logic       queue_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [3:0] listen_channel;

  // Hold the listen channel; writes land at once
  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel <= '0;
    end else if (cfg_valid && cfg_ready) begin
      listen_channel <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // Take a message whenever the queue has room
  assign msg_ready = !queue_full;
  assign push      = msg_valid && msg_ready;

  // Classify the message into a command
  always_comb begin
    push_cmd.op   = OP_NONE;
    push_cmd.note = data_first;
    if (channel == listen_channel) begin
      case (kind)
        KIND_NOTE_ON:  push_cmd.op = OP_NOTE_ON;
        KIND_NOTE_OFF: push_cmd.op = OP_NOTE_OFF;
        KIND_CTRL: begin
          if (data_first == SUSTAIN_CC) begin
            push_cmd.op = (data_second > SUSTAIN_THRESH) ? OP_SUS_ON : OP_SUS_OFF;
          end
        end
        default: push_cmd.op = OP_NONE;
      endcase
    end
  end

endmodule

[rtl/pva_cmd_fifo.sv]
// Short command queue between the front end and the voice engine.
`timescale 1ns / 1ps

module pva_cmd_fifo
  import pva_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          entries [CMD_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(CMD_DEPTH));
  assign head  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/pva_engine.sv]
// Back end: voice table, serial voice scan and result register.
`timescale 1ns / 1ps

module pva_engine
  import pva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_empty,
  input  cmd_t       cmd_head,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [2:0] voice_index,
  output logic       voice_hit,
  output logic       stole,
  output logic [6:0] replaced_note,
  output logic       sustain_active,
  output logic [7:0] sounding_mask
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

  state_t        state;
  cmd_t          cmd;
  logic [IW-1:0] scan_idx;

  // Voice table: note and stamp are meaningful only while the voice sounds
  logic [VOICES-1:0] voice_on;
  logic [VOICES-1:0] voice_key;
  logic [6:0]        voice_note [VOICES];
  logic [31:0]       voice_age  [VOICES];
  logic              sustain_held;
  logic [31:0]       age_counter;

  // Scan findings
  logic          match_found;
  logic [IW-1:0] match_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] old_idx;
  logic [31:0]   old_age;
  logic [6:0]    old_note;

  logic              rd_on;
  logic [6:0]        rd_note;
  logic [31:0]       rd_age;
  logic              apply_fire;
  logic [IW-1:0]     pick;
  logic [VOICES-1:0] on_next;
  logic [VOICES-1:0] key_next;
  logic              sus_next;
  logic [IW-1:0]     res_idx;
  logic              res_hit;
  logic              res_stole;
  logic [6:0]        res_replaced;
  logic [7:0]        mask_next;

  // Read the voice under the scan pointer
  assign rd_on   = voice_on[scan_idx];
  assign rd_note = voice_note[scan_idx];
  assign rd_age  = voice_age[scan_idx];

  assign pop        = (state == ST_IDLE) && !cmd_empty;
  assign apply_fire = (state == ST_APPLY) && (!res_valid || res_ready);

  // Choose the target voice: same note, else lowest free, else oldest
  assign pick = match_found ? match_idx : (free_found ? free_idx : old_idx);

  // Work out the table update and the result of the current command
  always_comb begin
    on_next      = voice_on;
    key_next     = voice_key;
    sus_next     = sustain_held;
    res_idx      = '0;
    res_hit      = 1'b0;
    res_stole    = 1'b0;
    res_replaced = '0;
    case (cmd.op)
      OP_NOTE_ON: begin
        on_next[pick]  = 1'b1;
        key_next[pick] = 1'b1;
        res_idx        = pick;
        res_hit        = 1'b1;
        res_stole      = !match_found && !free_found;
        if (match_found) begin
          res_replaced = cmd.note;
        end else if (!free_found) begin
          res_replaced = old_note;
        end
      end
      OP_NOTE_OFF: begin
        if (match_found) begin
          key_next[match_idx] = 1'b0;
          if (!sustain_held) begin
            on_next[match_idx] = 1'b0;
          end
          res_idx = match_idx;
          res_hit = 1'b1;
        end
      end
      OP_SUS_ON: sus_next = 1'b1;
      OP_SUS_OFF: begin
        sus_next = 1'b0;
        on_next  = voice_on & voice_key;
      end
      default: ;
    endcase
  end

  // Show voices zero to seven in the mask
  for (genvar g = 0; g < 8; g++) begin : g_mask
    if (g < VOICES) begin : g_live
      assign mask_next[g] = on_next[g];
    end else begin : g_pad
      assign mask_next[g] = 1'b0;
    end
  end

  // Sequence pop, scan and apply; hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_idx     <= '0;
      match_found  <= 1'b0;
      free_found   <= 1'b0;
      voice_on     <= '0;
      voice_key    <= '0;
      sustain_held <= 1'b0;
      age_counter  <= AGE_RESET;
      res_valid    <= 1'b0;
    end else begin
      if (res_valid && res_ready && !apply_fire) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            match_found <= 1'b0;
            free_found  <= 1'b0;
            scan_idx    <= '0;
            if (cmd_head.op == OP_NOTE_ON || cmd_head.op == OP_NOTE_OFF) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_APPLY;
            end
          end
        end
        ST_SCAN: begin
          if (rd_on && rd_note == cmd.note && !match_found) begin
            match_found <= 1'b1;
          end
          if (!rd_on && !free_found) begin
            free_found <= 1'b1;
          end
          if (scan_idx == IW'(VOICES - 1)) begin
            state <= ST_APPLY;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_APPLY: begin
          if (apply_fire) begin
            voice_on     <= on_next;
            voice_key    <= key_next;
            sustain_held <= sus_next;
            if (cmd.op == OP_NOTE_ON) begin
              age_counter <= age_counter + 1'b1;
            end
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture command, scan positions, voice payload and result fields
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= cmd_head;
    end
    if (state == ST_SCAN) begin
      if (rd_on && rd_note == cmd.note && !match_found) begin
        match_idx <= scan_idx;
      end
      if (!rd_on && !free_found) begin
        free_idx <= scan_idx;
      end
      if (scan_idx == '0 || rd_age < old_age) begin
        old_age  <= rd_age;
        old_idx  <= scan_idx;
        old_note <= rd_note;
      end
    end
    if (apply_fire) begin
      if (cmd.op == OP_NOTE_ON) begin
        voice_note[pick] <= cmd.note;
        voice_age[pick]  <= age_counter;
      end
      voice_index    <= 3'(res_idx);
      voice_hit      <= res_hit;
      stole          <= res_stole;
      replaced_note  <= res_replaced;
      sustain_active <= sus_next;
      sounding_mask  <= mask_next;
    end
  end

  // A steal is always an assignment
  a_stole_hits: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!stole || voice_hit))
    else $error("steal reported without a voice hit");

  // Releasing the pedal leaves no voice sounding with its key up
  a_sus_off_release: assert property (@(posedge clk) disable iff (rst)
    (apply_fire && cmd.op == OP_SUS_OFF) |=> ((voice_on & ~voice_key) == '0))
    else $error("voice with key up still sounds after sustain release");

  // Each note-on advances the age stamp by one
  a_age_step: assert property (@(posedge clk) disable iff (rst)
    (apply_fire && cmd.op == OP_NOTE_ON) |=> (age_counter == $past(age_counter) + 1'b1))
    else $error("age counter did not advance on note-on");

  // The assigned voice sounds after a note-on
  a_note_on_sounds: assert property (@(posedge clk) disable iff (rst)
    (apply_fire && cmd.op == OP_NOTE_ON) |=> voice_on[$past(pick)])
    else $error("assigned voice not sounding after note-on");

endmodule

[rtl/poly_voice_allocator_sustain.sv]
// Top level of the polyphonic voice allocator with sustain pedal.
//
//   Channel  Direction  Handshake              Payload
//   msg      in         msg_valid/msg_ready    kind, channel, data_first, data_second
//   res      out        res_valid/res_ready    voice_index, voice_hit, stole,
//                                              replaced_note, sustain_active,
//                                              sounding_mask
//   cfg      in         cfg_valid/cfg_ready    cfg_data (listen channel)
//
// A note-on or note-off passes through the engine in order: pop, then a serial
// scan that visits each voice of the voice table in turn, then apply; any
// other message is popped and applied with no scan. The voice scan sets the rate.
// Reset is synchronous: all voices silent, pedal up, age stamp one, channel 0.
// The front end keeps taking messages while the queue has room; a result
// waiting in the output register stalls only the apply step.
`timescale 1ns / 1ps

module poly_voice_allocator_sustain
  import pva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  input  logic       msg_valid,
  output logic       msg_ready,
  input  logic [1:0] kind,
  input  logic [3:0] channel,
  input  logic [6:0] data_first,
  input  logic [6:0] data_second,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [2:0] voice_index,
  output logic       voice_hit,
  output logic       stole,
  output logic [6:0] replaced_note,
  output logic       sustain_active,
  output logic [7:0] sounding_mask
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic empty;
  logic full;

  pva_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .msg_valid   (msg_valid),
    .msg_ready   (msg_ready),
    .kind        (kind),
    .channel     (channel),
    .data_first  (data_first),
    .data_second (data_second),
    .queue_full  (full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  pva_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  pva_engine #(
    .VOICES (VOICES)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cmd_empty      (empty),
    .cmd_head       (head),
    .pop            (pop),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .voice_index    (voice_index),
    .voice_hit      (voice_hit),
    .stole          (stole),
    .replaced_note  (replaced_note),
    .sustain_active (sustain_active),
    .sounding_mask  (sounding_mask)
  );

endmodule
